>>> hdl/jsu_pkg.sv
// ---------------------------------------------------------------------------
// jsu_pkg: shared types and constants for the JSON string unescaper
// Decoder modes, result status codes, UTF-8 continuation rules, character
// codes and the decoder state and result group structures.
// ---------------------------------------------------------------------------
package jsu_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_STR  = 3'd1,
    MODE_ESC  = 3'd2,
    MODE_HEX1 = 3'd3,
    MODE_SBS  = 3'd4,
    MODE_SU   = 3'd5,
    MODE_HEX2 = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    ST_BYTE   = 3'd0,
    ST_DONE   = 3'd1,
    ST_EOF    = 3'd2,
    ST_EXPECT = 3'd3,
    ST_SYNTAX = 3'd4,
    ST_UTF8   = 3'd5
  } status_t;

  // Allowed range of the next continuation byte
  typedef enum logic [2:0] {
    RULE_ANY = 3'd0,  // 80-BF
    RULE_A0  = 3'd1,  // A0-BF
    RULE_9F  = 3'd2,  // 80-9F
    RULE_90  = 3'd3,  // 90-BF
    RULE_8F  = 3'd4   // 80-8F
  } rule_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_FF = 8'h0c;
  localparam logic [7:0] CH_BS = 8'h08;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_N = 8'h6e;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_U = 8'h75;

  localparam int GRP_SIZE = 4;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] hex_value;
    logic [1:0]  hex_count;
    logic        hex_bad;
    logic [9:0]  high_half;
    logic [1:0]  utf8_need;
    rule_t       utf8_rule;
    logic        utf8_bad;
  } dec_state_t;

  localparam dec_state_t STATE_RESET = '{
    mode:      MODE_IDLE,
    hex_value: 16'h0000,
    hex_count: 2'd0,
    hex_bad:   1'b0,
    high_half: 10'd0,
    utf8_need: 2'd0,
    utf8_rule: RULE_ANY,
    utf8_bad:  1'b0
  };

  // Results caused by one item: either count data bytes or one status result
  typedef struct packed {
    logic [2:0]                   count;
    logic [GRP_SIZE-1:0][7:0]     bytes;
    status_t                      status;
  } grp_t;

endpackage

>>> hdl/jsu_decode.sv
// ---------------------------------------------------------------------------
// jsu_decode: per-byte decode step
// Combinational next state and result group for one buffer byte or an
// end-of-buffer mark.
// ---------------------------------------------------------------------------
module jsu_decode (
  input  jsu_pkg::dec_state_t st,
  input  logic [7:0]          ch,
  input  logic                at_end,
  output jsu_pkg::dec_state_t st_next,
  output jsu_pkg::grp_t       grp
);

  logic            hd_ok;
  logic [3:0]      hd_val;
  logic [15:0]     hex_new;
  logic            hex_bad_new;
  logic [20:0]     scalar;
  logic [2:0]      enc_count;
  logic [3:0][7:0] enc_bytes;
  logic            fin_valid;
  jsu_pkg::status_t fin_code;
  logic [7:0]      lo;
  logic [7:0]      hi;

  // Hex digit value
  always_comb begin
    hd_ok  = 1'b1;
    hd_val = 4'h0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      hd_val = ch[3:0];
    end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
      hd_val = ch[3:0] + 4'd9;
    end else begin
      hd_ok = 1'b0;
    end
  end

  assign hex_new     = {st.hex_value[11:0], hd_val};
  assign hex_bad_new = st.hex_bad | ~hd_ok;
  assign scalar = (st.mode == jsu_pkg::MODE_HEX1) ? {5'd0, hex_new}
                : 21'h010000 + {1'b0, st.high_half, hex_new[9:0]};

  // UTF-8 encoder of one scalar value
  always_comb begin
    enc_bytes = '0;
    if (scalar <= 21'h00007f) begin
      enc_count    = 3'd1;
      enc_bytes[0] = scalar[7:0];
    end else if (scalar <= 21'h0007ff) begin
      enc_count    = 3'd2;
      enc_bytes[0] = {3'b110, scalar[10:6]};
      enc_bytes[1] = {2'b10, scalar[5:0]};
    end else if (scalar <= 21'h00ffff) begin
      enc_count    = 3'd3;
      enc_bytes[0] = {4'b1110, scalar[15:12]};
      enc_bytes[1] = {2'b10, scalar[11:6]};
      enc_bytes[2] = {2'b10, scalar[5:0]};
    end else begin
      enc_count    = 3'd4;
      enc_bytes[0] = {5'b11110, scalar[20:18]};
      enc_bytes[1] = {2'b10, scalar[17:12]};
      enc_bytes[2] = {2'b10, scalar[11:6]};
      enc_bytes[3] = {2'b10, scalar[5:0]};
    end
  end

  // Continuation byte range
  always_comb begin
    lo = 8'h80;
    hi = 8'hbf;
    unique case (st.utf8_rule)
      jsu_pkg::RULE_A0: lo = 8'ha0;
      jsu_pkg::RULE_9F: hi = 8'h9f;
      jsu_pkg::RULE_90: lo = 8'h90;
      jsu_pkg::RULE_8F: hi = 8'h8f;
      default: ;
    endcase
  end

  always_comb begin
    st_next    = st;
    grp.count  = 3'd0;
    grp.bytes  = '0;
    grp.status = jsu_pkg::ST_BYTE;
    fin_valid  = 1'b0;
    fin_code   = jsu_pkg::ST_EOF;

    if (at_end) begin
      fin_valid = 1'b1;
      if (st.mode == jsu_pkg::MODE_SBS || st.mode == jsu_pkg::MODE_SU ||
          st.mode == jsu_pkg::MODE_HEX2) begin
        fin_code = jsu_pkg::ST_UTF8;
      end
    end else begin
      unique case (st.mode)
        jsu_pkg::MODE_STR: begin
          if (ch == jsu_pkg::CH_QUOTE) begin
            fin_valid = 1'b1;
            fin_code  = (st.utf8_bad || st.utf8_need != 2'd0) ? jsu_pkg::ST_UTF8
                                                                : jsu_pkg::ST_DONE;
          end else if (ch < jsu_pkg::CH_SPACE) begin
            fin_valid = 1'b1;
            fin_code  = jsu_pkg::ST_SYNTAX;
          end else if (ch == jsu_pkg::CH_BSLASH) begin
            // escape breaks an open raw sequence
            if (st.utf8_need != 2'd0) begin
              st_next.utf8_bad  = 1'b1;
              st_next.utf8_need = 2'd0;
              st_next.utf8_rule = jsu_pkg::RULE_ANY;
            end
            st_next.mode = jsu_pkg::MODE_ESC;
          end else begin
            grp.count    = 3'd1;
            grp.bytes[0] = ch;
            if (st.utf8_need != 2'd0) begin
              st_next.utf8_rule = jsu_pkg::RULE_ANY;
              if (ch < lo || ch > hi) begin
                st_next.utf8_bad  = 1'b1;
                st_next.utf8_need = 2'd0;
              end else begin
                st_next.utf8_need = st.utf8_need - 2'd1;
              end
            end else if (ch >= 8'hc2 && ch <= 8'hdf) begin
              st_next.utf8_need = 2'd1;
            end else if (ch >= 8'he0 && ch <= 8'hef) begin
              st_next.utf8_need = 2'd2;
              st_next.utf8_rule = (ch == 8'he0) ? jsu_pkg::RULE_A0
                                : (ch == 8'hed) ? jsu_pkg::RULE_9F : jsu_pkg::RULE_ANY;
            end else if (ch >= 8'hf0 && ch <= 8'hf4) begin
              st_next.utf8_need = 2'd3;
              st_next.utf8_rule = (ch == 8'hf0) ? jsu_pkg::RULE_90
                                : (ch == 8'hf4) ? jsu_pkg::RULE_8F : jsu_pkg::RULE_ANY;
            end else if (ch >= 8'h80) begin
              st_next.utf8_bad = 1'b1;
            end
          end
        end
        jsu_pkg::MODE_ESC: begin
          grp.count = 3'd1;
          st_next.mode = jsu_pkg::MODE_STR;
          unique case (ch)
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: grp.bytes[0] = ch;
            jsu_pkg::CH_B: grp.bytes[0] = jsu_pkg::CH_BS;
            jsu_pkg::CH_F: grp.bytes[0] = jsu_pkg::CH_FF;
            jsu_pkg::CH_N: grp.bytes[0] = jsu_pkg::CH_LF;
            jsu_pkg::CH_R: grp.bytes[0] = jsu_pkg::CH_CR;
            jsu_pkg::CH_T: grp.bytes[0] = jsu_pkg::CH_TAB;
            jsu_pkg::CH_U: begin
              grp.count         = 3'd0;
              st_next.mode      = jsu_pkg::MODE_HEX1;
              st_next.hex_value = 16'h0000;
              st_next.hex_count = 2'd0;
              st_next.hex_bad   = 1'b0;
            end
            default: begin
              grp.count = 3'd0;
              fin_valid = 1'b1;
              fin_code  = jsu_pkg::ST_SYNTAX;
            end
          endcase
        end
        jsu_pkg::MODE_SBS: begin
          if (ch == jsu_pkg::CH_BSLASH) begin
            st_next.mode = jsu_pkg::MODE_SU;
          end else begin
            fin_valid = 1'b1;
            fin_code  = jsu_pkg::ST_UTF8;
          end
        end
        jsu_pkg::MODE_SU: begin
          if (ch == jsu_pkg::CH_U) begin
            st_next.mode      = jsu_pkg::MODE_HEX2;
            st_next.hex_value = 16'h0000;
            st_next.hex_count = 2'd0;
            st_next.hex_bad   = 1'b0;
          end else begin
            fin_valid = 1'b1;
            fin_code  = jsu_pkg::ST_UTF8;
          end
        end
        jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
          st_next.hex_value = hex_new;
          st_next.hex_bad   = hex_bad_new;
          if (st.hex_count != 2'd3) begin
            st_next.hex_count = st.hex_count + 2'd1;
          end else if (hex_bad_new) begin
            fin_valid = 1'b1;
            fin_code  = jsu_pkg::ST_SYNTAX;
          end else if (st.mode == jsu_pkg::MODE_HEX1 && hex_new[15:10] == 6'b110110) begin
            // high surrogate: wait for the low half
            st_next.high_half = hex_new[9:0];
            st_next.mode      = jsu_pkg::MODE_SBS;
          end else if ((st.mode == jsu_pkg::MODE_HEX1) == (hex_new[15:10] == 6'b110111)) begin
            // lone low surrogate, or a second half that is not one
            fin_valid = 1'b1;
            fin_code  = jsu_pkg::ST_UTF8;
          end else begin
            grp.count    = enc_count;
            grp.bytes    = enc_bytes;
            st_next.mode = jsu_pkg::MODE_STR;
          end
        end
        jsu_pkg::MODE_IDLE: begin
          if (ch == jsu_pkg::CH_QUOTE) begin
            st_next      = jsu_pkg::STATE_RESET;
            st_next.mode = jsu_pkg::MODE_STR;
          end else if (!(ch == jsu_pkg::CH_SPACE || ch == jsu_pkg::CH_LF ||
                         ch == jsu_pkg::CH_CR || ch == jsu_pkg::CH_TAB)) begin
            fin_valid = 1'b1;
            fin_code  = jsu_pkg::ST_EXPECT;
          end
        end
        default: begin
          st_next = jsu_pkg::STATE_RESET;
        end
      endcase
    end

    if (fin_valid) begin
      st_next    = jsu_pkg::STATE_RESET;
      grp.count  = 3'd1;
      grp.bytes  = '0;
      grp.status = fin_code;
    end
  end

endmodule

>>> hdl/jsu_out.sv
// ---------------------------------------------------------------------------
// jsu_out: result group register and serializer
// Holds the results of one item and hands them out one per transaction.
// ---------------------------------------------------------------------------
module jsu_out (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  jsu_pkg::grp_t   grp,
  output logic            can_load,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic [2:0]      status,
  output logic            last
);

  logic                 busy;
  logic [1:0]           idx;
  logic [1:0]           cnt;
  logic [3:0][7:0]      bytes;
  jsu_pkg::status_t     grp_status;

  assign last      = (idx == cnt);
  assign can_load  = !busy || (out_ready && last);
  assign out_valid = busy;
  assign out_byte  = (grp_status == jsu_pkg::ST_BYTE) ? bytes[idx] : 8'h00;
  assign status    = grp_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (busy && out_ready) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes      <= grp.bytes;
      cnt        <= 2'(grp.count - 3'd1);
      grp_status <= grp.status;
    end
  end

endmodule

>>> hdl/json_string_unescape_utf8.sv
// ---------------------------------------------------------------------------
// json_string_unescape_utf8: JSON string decoder to UTF-8 bytes
// One buffer byte per input transaction; decoded bytes and a final status
// per output transaction.
// ---------------------------------------------------------------------------
// Input channel: in_valid/in_ready carry data_byte and at_end. at_end marks
// the end of the buffer and data_byte is then ignored.
// Output channel: out_valid/out_ready carry out_byte, status and last.
// status 0 is a decoded byte, 1 string done, 2 end of buffer, 3 expected
// quote, 4 syntax error, 5 UTF-8 error. last flags the final result of the
// input transaction that caused it. A byte that causes no result (leading
// whitespace, the opening quote, a backslash, hex digits) produces nothing.
// Path: an accepted byte is held in the input register, then decoded and
// loaded into the result group register, which offers its first result.
// Throughput: one input byte per cycle while each byte gives at most one
// result and out_ready stays high. A \u escape gives up to four bytes,
// which the result register hands out one per cycle while out_ready is
// high, holding the input side meanwhile.
// Reset: synchronous, clears the decoder to idle (awaiting opening quote)
// and drops any pending results.
// Stall: when out_ready is low, the result register holds, the input
// register fills, and in_ready falls once both are occupied.
// ---------------------------------------------------------------------------
module json_string_unescape_utf8 (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       at_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [2:0] status,
  output logic       last
);

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_end;

  // decoder state
  jsu_pkg::dec_state_t st;
  jsu_pkg::dec_state_t st_next;
  jsu_pkg::grp_t       grp;

  logic can_load;
  logic advance;

  // Advance the held byte when its results fit into the result register;
  // bytes without results always advance.
  assign advance  = s1_valid && (grp.count == 3'd0 || can_load);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= data_byte;
      s1_end  <= at_end;
    end
  end

  // Update the decoder state only when the held byte advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= jsu_pkg::STATE_RESET;
    end else if (advance) begin
      st <= st_next;
    end
  end

  jsu_decode u_decode (
    .st      (st),
    .ch      (s1_byte),
    .at_end  (s1_end),
    .st_next (st_next),
    .grp     (grp)
  );

  jsu_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && grp.count != 3'd0),
    .grp       (grp),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .status    (status),
    .last      (last)
  );

endmodule

>>> sim/json_string_unescape_utf8_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// json_string_unescape_utf8_tb: self-checking bench for the JSON unescaper
// Streams directed and random JSON byte sequences into the decoder, predicts
// every decoded byte and final status with a behavioral copy of the decoder,
// and checks each output transaction in order under random idle and stalls.
// ---------------------------------------------------------------------------
module json_string_unescape_utf8_tb;

  // One expected output transaction
  typedef struct {
    logic [7:0]       value;
    jsu_pkg::status_t code;
    logic             last;
  } result_t;

  // One input transaction
  typedef struct {
    logic [7:0] value;
    logic       at_end;
  } item_t;

  // Behavioral decoder plus the queue of decoded results it predicts.
  class unescape_scoreboard;
    jsu_pkg::dec_state_t st;
    result_t             expected_q[$];
    int                  errors;

    function new();
      st = jsu_pkg::STATE_RESET;
      errors = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function void push(logic [7:0] value, jsu_pkg::status_t code);
      result_t r;
      r.value = value;
      r.code = code;
      r.last = 1'b0;
      expected_q.push_back(r);
    endfunction

    function int hex_nibble(logic [7:0] ch);
      if (ch >= "0" && ch <= "9") return int'(ch) - 48;
      if (ch >= "a" && ch <= "f") return int'(ch) - 87;
      if (ch >= "A" && ch <= "F") return int'(ch) - 55;
      return -1;
    endfunction

    function void open_hex(jsu_pkg::mode_t m);
      st.mode = m;
      st.hex_value = 16'h0000;
      st.hex_count = 2'd0;
      st.hex_bad = 1'b0;
    endfunction

    // RFC 3629 tracking of raw string bytes
    function void track_utf8(logic [7:0] b);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = 8'h80;
      hi = 8'hbf;
      if (st.utf8_need != 2'd0) begin
        case (st.utf8_rule)
          jsu_pkg::RULE_A0: lo = 8'ha0;
          jsu_pkg::RULE_9F: hi = 8'h9f;
          jsu_pkg::RULE_90: lo = 8'h90;
          jsu_pkg::RULE_8F: hi = 8'h8f;
          default: ;
        endcase
        st.utf8_rule = jsu_pkg::RULE_ANY;
        if (b < lo || b > hi) begin
          st.utf8_bad = 1'b1;
          st.utf8_need = 2'd0;
        end else begin
          st.utf8_need = st.utf8_need - 2'd1;
        end
      end else if (b >= 8'hc2 && b <= 8'hdf) begin
        st.utf8_need = 2'd1;
      end else if (b >= 8'he0 && b <= 8'hef) begin
        st.utf8_need = 2'd2;
        if (b == 8'he0) st.utf8_rule = jsu_pkg::RULE_A0;
        else if (b == 8'hed) st.utf8_rule = jsu_pkg::RULE_9F;
        else st.utf8_rule = jsu_pkg::RULE_ANY;
      end else if (b >= 8'hf0 && b <= 8'hf4) begin
        st.utf8_need = 2'd3;
        if (b == 8'hf0) st.utf8_rule = jsu_pkg::RULE_90;
        else if (b == 8'hf4) st.utf8_rule = jsu_pkg::RULE_8F;
        else st.utf8_rule = jsu_pkg::RULE_ANY;
      end else if (b >= 8'h80) begin
        st.utf8_bad = 1'b1;
      end
    endfunction

    function void push_scalar(int unsigned s);
      if (s <= 32'h7f) begin
        push(8'(s), jsu_pkg::ST_BYTE);
      end else if (s <= 32'h7ff) begin
        push(8'(32'hc0 | (s >> 6)), jsu_pkg::ST_BYTE);
        push(8'(32'h80 | (s & 32'h3f)), jsu_pkg::ST_BYTE);
      end else if (s <= 32'hffff) begin
        push(8'(32'he0 | (s >> 12)), jsu_pkg::ST_BYTE);
        push(8'(32'h80 | ((s >> 6) & 32'h3f)), jsu_pkg::ST_BYTE);
        push(8'(32'h80 | (s & 32'h3f)), jsu_pkg::ST_BYTE);
      end else begin
        push(8'(32'hf0 | ((s >> 18) & 32'h07)), jsu_pkg::ST_BYTE);
        push(8'(32'h80 | ((s >> 12) & 32'h3f)), jsu_pkg::ST_BYTE);
        push(8'(32'h80 | ((s >> 6) & 32'h3f)), jsu_pkg::ST_BYTE);
        push(8'(32'h80 | (s & 32'h3f)), jsu_pkg::ST_BYTE);
      end
    endfunction

    // Advance the decoder by one accepted input transaction.
    function void note_input(logic [7:0] ch, logic at_end);
      int               first;
      int               d;
      bit               has_final;
      jsu_pkg::status_t final_code;
      bit               esc_ok;
      logic [7:0]       esc_byte;
      first = expected_q.size();
      has_final = 1'b0;
      final_code = jsu_pkg::ST_DONE;
      esc_ok = 1'b1;
      esc_byte = ch;
      if (at_end) begin
        has_final = 1'b1;
        if (st.mode inside {jsu_pkg::MODE_SBS, jsu_pkg::MODE_SU, jsu_pkg::MODE_HEX2})
          final_code = jsu_pkg::ST_UTF8;
        else final_code = jsu_pkg::ST_EOF;
      end else begin
        case (st.mode)
          jsu_pkg::MODE_IDLE: begin
            if (ch == jsu_pkg::CH_QUOTE) begin
              st = jsu_pkg::STATE_RESET;
              st.mode = jsu_pkg::MODE_STR;
            end else if (!(ch inside {jsu_pkg::CH_SPACE, jsu_pkg::CH_LF, jsu_pkg::CH_CR,
                                      jsu_pkg::CH_TAB})) begin
              has_final = 1'b1;
              final_code = jsu_pkg::ST_EXPECT;
            end
          end
          jsu_pkg::MODE_STR: begin
            if (ch == jsu_pkg::CH_QUOTE) begin
              has_final = 1'b1;
              if (st.utf8_bad || st.utf8_need != 2'd0) final_code = jsu_pkg::ST_UTF8;
              else final_code = jsu_pkg::ST_DONE;
            end else if (ch < jsu_pkg::CH_SPACE) begin
              has_final = 1'b1;
              final_code = jsu_pkg::ST_SYNTAX;
            end else if (ch == jsu_pkg::CH_BSLASH) begin
              // an escape breaks any raw sequence in progress
              if (st.utf8_need != 2'd0) begin
                st.utf8_bad = 1'b1;
                st.utf8_need = 2'd0;
                st.utf8_rule = jsu_pkg::RULE_ANY;
              end
              st.mode = jsu_pkg::MODE_ESC;
            end else begin
              track_utf8(ch);
              push(ch, jsu_pkg::ST_BYTE);
            end
          end
          jsu_pkg::MODE_ESC: begin
            case (ch)
              jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: esc_byte = ch;
              jsu_pkg::CH_B: esc_byte = jsu_pkg::CH_BS;
              jsu_pkg::CH_F: esc_byte = jsu_pkg::CH_FF;
              jsu_pkg::CH_N: esc_byte = jsu_pkg::CH_LF;
              jsu_pkg::CH_R: esc_byte = jsu_pkg::CH_CR;
              jsu_pkg::CH_T: esc_byte = jsu_pkg::CH_TAB;
              default: esc_ok = 1'b0;
            endcase
            if (ch == jsu_pkg::CH_U) begin
              open_hex(jsu_pkg::MODE_HEX1);
            end else if (esc_ok) begin
              push(esc_byte, jsu_pkg::ST_BYTE);
              st.mode = jsu_pkg::MODE_STR;
            end else begin
              has_final = 1'b1;
              final_code = jsu_pkg::ST_SYNTAX;
            end
          end
          jsu_pkg::MODE_SBS: begin
            if (ch == jsu_pkg::CH_BSLASH) begin
              st.mode = jsu_pkg::MODE_SU;
            end else begin
              has_final = 1'b1;
              final_code = jsu_pkg::ST_UTF8;
            end
          end
          jsu_pkg::MODE_SU: begin
            if (ch == jsu_pkg::CH_U) begin
              open_hex(jsu_pkg::MODE_HEX2);
            end else begin
              has_final = 1'b1;
              final_code = jsu_pkg::ST_UTF8;
            end
          end
          default: begin
            d = hex_nibble(ch);
            if (d < 0) begin
              st.hex_bad = 1'b1;
              d = 0;
            end
            st.hex_value = {st.hex_value[11:0], 4'(d)};
            if (st.hex_count != 2'd3) begin
              st.hex_count = st.hex_count + 2'd1;
            end else if (st.hex_bad) begin
              has_final = 1'b1;
              final_code = jsu_pkg::ST_SYNTAX;
            end else if (st.mode == jsu_pkg::MODE_HEX1) begin
              if (st.hex_value >= 16'hd800 && st.hex_value <= 16'hdbff) begin
                st.high_half = st.hex_value[9:0];
                st.mode = jsu_pkg::MODE_SBS;
              end else if (st.hex_value >= 16'hdc00 && st.hex_value <= 16'hdfff) begin
                has_final = 1'b1;
                final_code = jsu_pkg::ST_UTF8;
              end else begin
                push_scalar(st.hex_value);
                st.mode = jsu_pkg::MODE_STR;
              end
            end else if (st.hex_value < 16'hdc00 || st.hex_value > 16'hdfff) begin
              has_final = 1'b1;
              final_code = jsu_pkg::ST_UTF8;
            end else begin
              push_scalar(32'h10000 + {12'd0, st.high_half, st.hex_value[9:0]});
              st.mode = jsu_pkg::MODE_STR;
            end
          end
        endcase
      end
      if (has_final) begin
        push(8'h00, final_code);
        st = jsu_pkg::STATE_RESET;
      end
      if (expected_q.size() > first) expected_q[expected_q.size() - 1].last = 1'b1;
    endfunction

    // Compare one accepted output transaction against the oldest prediction.
    task check_result(logic [7:0] value, logic [2:0] code, logic last);
      result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result byte %02h status %0d last %0d",
                         value, code, last));
        return;
      end
      want = expected_q.pop_front();
      if (value !== want.value)
        report($sformatf("out_byte %02h, want %02h", value, want.value));
      if (code !== want.code)
        report($sformatf("status %0d, want %0d", code, want.code));
      if (last !== want.last)
        report($sformatf("last %0d, want %0d", last, want.last));
    endtask
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] data_byte;
  logic       at_end;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic [2:0] status;
  logic       last;

  unescape_scoreboard sb;
  item_t              stim_q[$];
  bit                 quiet = 1'b0;   // suppresses idling on both sides

  json_string_unescape_utf8 dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .at_end    (at_end),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .status    (status),
    .last      (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Stimulus building. Every byte lands in stim_q, which sets the length of
  // the run.
  // -------------------------------------------------------------------------
  function automatic void put(logic [7:0] b);
    item_t it;
    it.value = b;
    it.at_end = 1'b0;
    stim_q.push_back(it);
  endfunction

  // Mark end of buffer; the byte lane carries junk that must be ignored.
  function automatic void put_end();
    item_t it;
    it.value = 8'($urandom);
    it.at_end = 1'b1;
    stim_q.push_back(it);
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'($urandom_range(8'hbf, 8'h80));
  endfunction

  function automatic logic [7:0] pick_escape();
    case ($urandom_range(7))
      0: return jsu_pkg::CH_QUOTE;
      1: return jsu_pkg::CH_BSLASH;
      2: return jsu_pkg::CH_SLASH;
      3: return jsu_pkg::CH_B;
      4: return jsu_pkg::CH_F;
      5: return jsu_pkg::CH_N;
      6: return jsu_pkg::CH_R;
      default: return jsu_pkg::CH_T;
    endcase
  endfunction

  // Emit the first `count` hex digits of v in mixed case; replace the digit at
  // position bad_at (0 = most significant) with a non-hex byte.
  function automatic void put_hex4(logic [15:0] v, int bad_at, int count);
    logic [3:0] nib;
    logic [7:0] b;
    for (int i = 0; i < count; i++) begin
      nib = v[15 - 4*i -: 4];
      if (i == bad_at) begin
        do b = 8'($urandom);
        while (b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
      end else if (nib < 4'd10) begin
        b = 8'h30 + 8'(nib);
      end else begin
        b = (($urandom_range(1) != 0) ? 8'h61 : 8'h41) + 8'(nib) - 8'd10;
      end
      put(b);
    end
  endfunction

  // One well-formed chunk of string content.
  function automatic void put_piece();
    logic [7:0]  b;
    logic [15:0] v;
    case ($urandom_range(8))
      0, 1: begin
        do b = 8'($urandom_range(8'h7f, 8'h20));
        while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH);
        put(b);
      end
      2: begin
        put(8'($urandom_range(8'hdf, 8'hc2)));
        put(cont_byte());
      end
      3: begin
        b = 8'($urandom_range(8'hef, 8'he0));
        put(b);
        if (b == 8'he0) put(8'($urandom_range(8'hbf, 8'ha0)));
        else if (b == 8'hed) put(8'($urandom_range(8'h9f, 8'h80)));
        else put(cont_byte());
        put(cont_byte());
      end
      4: begin
        b = 8'($urandom_range(8'hf4, 8'hf0));
        put(b);
        if (b == 8'hf0) put(8'($urandom_range(8'hbf, 8'h90)));
        else if (b == 8'hf4) put(8'($urandom_range(8'h8f, 8'h80)));
        else put(cont_byte());
        put(cont_byte());
        put(cont_byte());
      end
      5: begin
        put(jsu_pkg::CH_BSLASH);
        put(pick_escape());
      end
      6, 7: begin
        // spread BMP escapes over the 1, 2 and 3 byte encodings
        case ($urandom_range(3))
          0: v = 16'($urandom_range(16'h7f));
          1: v = 16'($urandom_range(16'h7ff, 16'h80));
          2: v = ($urandom_range(1) != 0) ? 16'hffff : 16'h0000;
          default: begin
            do v = 16'($urandom_range(16'hffff, 16'h800));
            while (v inside {[16'hd800:16'hdfff]});
          end
        endcase
        put(jsu_pkg::CH_BSLASH);
        put(jsu_pkg::CH_U);
        put_hex4(v, -1, 4);
      end
      default: begin
        put(jsu_pkg::CH_BSLASH);
        put(jsu_pkg::CH_U);
        put_hex4(16'hd800 | 16'($urandom_range(10'h3ff)), -1, 4);
        put(jsu_pkg::CH_BSLASH);
        put(jsu_pkg::CH_U);
        put_hex4(16'hdc00 | 16'($urandom_range(10'h3ff)), -1, 4);
      end
    endcase
  endfunction

  // One broken chunk. Return 1 when it ends the string with an error.
  function automatic bit put_fault();
    logic [7:0]  b;
    logic [15:0] v;
    int          pos;
    case ($urandom_range(9))
      0: begin
        put(8'($urandom_range(8'h1f, 8'h00)));
        return 1'b1;
      end
      1: begin
        put(jsu_pkg::CH_BSLASH);
        do b = 8'($urandom);
        while (b inside {jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH,
                         jsu_pkg::CH_B, jsu_pkg::CH_F, jsu_pkg::CH_N, jsu_pkg::CH_R,
                         jsu_pkg::CH_T, jsu_pkg::CH_U});
        put(b);
        return 1'b1;
      end
      2: begin
        // bad hex digit, sometimes cut short by the end of the buffer
        put(jsu_pkg::CH_BSLASH);
        put(jsu_pkg::CH_U);
        v = 16'($urandom);
        if ($urandom_range(3) == 0) begin
          pos = $urandom_range(2);
          put_hex4(v, pos, $urandom_range(3, pos + 1));
          put_end();
        end else begin
          put_hex4(v, $urandom_range(3), 4);
        end
        return 1'b1;
      end
      3: begin
        put(jsu_pkg::CH_BSLASH);
        put(jsu_pkg::CH_U);
        put_hex4(16'hdc00 | 16'($urandom_range(10'h3ff)), -1, 4);
        return 1'b1;
      end
      4: begin
        // high surrogate with a missing or wrong low half
        put(jsu_pkg::CH_BSLASH);
        put(jsu_pkg::CH_U);
        put_hex4(16'hd800 | 16'($urandom_range(10'h3ff)), -1, 4);
        case ($urandom_range(3))
          0: begin
            do b = 8'($urandom);
            while (b == jsu_pkg::CH_BSLASH);
            put(b);
          end
          1: begin
            put(jsu_pkg::CH_BSLASH);
            do b = 8'($urandom);
            while (b == jsu_pkg::CH_U);
            put(b);
          end
          2: begin
            put(jsu_pkg::CH_BSLASH);
            put(jsu_pkg::CH_U);
            do v = 16'($urandom);
            while (v inside {[16'hdc00:16'hdfff]});
            put_hex4(v, -1, 4);
          end
          default: put_end();
        endcase
        return 1'b1;
      end
      5: begin
        // buffer ends inside the string
        case ($urandom_range(2))
          0: ;
          1: put(jsu_pkg::CH_BSLASH);
          default: begin
            put(jsu_pkg::CH_BSLASH);
            put(jsu_pkg::CH_U);
            put_hex4(16'($urandom), -1, $urandom_range(3));
          end
        endcase
        put_end();
        return 1'b1;
      end
      6: begin
        put(8'($urandom_range(8'hff, 8'h80)));
        put(8'($urandom_range(8'hff, 8'h80)));
        return 1'b0;
      end
      7: begin
        put(8'($urandom_range(8'hf4, 8'hc2)));
        put(jsu_pkg::CH_BSLASH);
        put(pick_escape());
        return 1'b0;
      end
      8: begin
        put(8'($urandom_range(8'hef, 8'he1)));
        put(cont_byte());
        return 1'b0;
      end
      default: begin
        repeat ($urandom_range(3, 1)) put(8'($urandom));
        return 1'b0;
      end
    endcase
  endfunction

  // Whitespace, opening quote, content, closing quote; optionally one fault.
  function automatic void put_string(bit faulty);
    int pieces;
    int fault_at;
    bit ended;
    repeat ($urandom_range(2)) begin
      case ($urandom_range(3))
        0: put(jsu_pkg::CH_SPACE);
        1: put(jsu_pkg::CH_LF);
        2: put(jsu_pkg::CH_CR);
        default: put(jsu_pkg::CH_TAB);
      endcase
    end
    put(jsu_pkg::CH_QUOTE);
    pieces = $urandom_range(6);
    fault_at = faulty ? $urandom_range(pieces) : -1;
    ended = 1'b0;
    for (int i = 0; i <= pieces && !ended; i++) begin
      if (i == fault_at) ended = put_fault();
      if (i < pieces && !ended) put_piece();
    end
    if (!ended) put(jsu_pkg::CH_QUOTE);
  endfunction

  // -------------------------------------------------------------------------
  // Input driver: change inputs at the falling edge, detect the transaction
  // at the rising edge. Hold valid and payload until accepted.
  // -------------------------------------------------------------------------
  task automatic send_item(item_t it);
    while (!quiet && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= it.value;
    at_end    <= it.at_end;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    sb.note_input(it.value, it.at_end);
    @(negedge clk);
  endtask

  // Output side: drop ready at random, except inside the quiet window.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= quiet || ($urandom_range(99) >= 12);
    end
  end

  // Check every output transaction at the edge that accepts it.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_byte, status, last);
  end

  initial begin
    int k;
    rst       = 1'b1;
    in_valid  = 1'b0;
    data_byte = 8'h00;
    at_end    = 1'b0;
    sb = new();

    // Directed: stray byte while idle, end of buffer while idle, DEL as string
    // data, a NUL control byte, unknown escape, end of buffer after a
    // high surrogate, a lone low surrogate, and an unfinished raw sequence.
    put(8'hff);
    put_end();
    put(jsu_pkg::CH_TAB);
    put(jsu_pkg::CH_QUOTE);
    put(8'h7f);
    put(8'h00);
    put(jsu_pkg::CH_QUOTE);
    put(jsu_pkg::CH_BSLASH);
    put("q");
    put(jsu_pkg::CH_QUOTE);
    put(jsu_pkg::CH_BSLASH);
    put(jsu_pkg::CH_U);
    put_hex4(16'hdbff, -1, 4);
    put_end();
    put(jsu_pkg::CH_QUOTE);
    put(jsu_pkg::CH_BSLASH);
    put(jsu_pkg::CH_U);
    put_hex4(16'hdfff, -1, 4);
    put(jsu_pkg::CH_QUOTE);
    put(8'he2);
    put(jsu_pkg::CH_QUOTE);

    // Random: mostly well-formed strings, mixed with faulty strings and raw noise
    // that always ends with an end-of-buffer mark to resync the decoder.
    while (stim_q.size() < 300) begin
      k = $urandom_range(99);
      if (k < 65) begin
        put_string(1'b0);
      end else if (k < 90) begin
        put_string(1'b1);
      end else begin
        repeat ($urandom_range(5, 1)) put(8'($urandom));
        put_end();
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (stim_q[i]) begin
      quiet = (i >= 120 && i < 220);
      send_item(stim_q[i]);
    end
    in_valid <= 1'b0;
    quiet = 1'b0;

    // Drain outstanding results, then watch for strays.
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
